// ===== sv/kwdt_pkg.sv =====
// ----------------------------------------------------------------------------
// kwdt_pkg
// Shared types and constants for the keyed watchdog timer: transfer payloads,
// operation codes, key words, control word bit positions and key states.
// ----------------------------------------------------------------------------
`default_nettype none

package kwdt_pkg;

    // Operation codes carried in the input transfer
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } kwdt_op_t;

    // Key words
    localparam logic [15:0] KEY_PING_A = 16'hAAAA;
    localparam logic [15:0] KEY_PING_B = 16'h5555;
    localparam logic [15:0] KEY_UNLK_A = 16'h3333;
    localparam logic [15:0] KEY_UNLK_B = 16'hCCCC;

    // Control word bit positions
    localparam int unsigned BIT_ENABLE = 15;
    localparam int unsigned BIT_RSTEN  = 14;
    localparam int unsigned BIT_IRQ    = 12;
    localparam int unsigned EXP_BITS   = 8;

    // Key sequence tracking
    typedef enum logic [3:0] {
        KEY_IDLE = 4'b0001,
        KEY_PING = 4'b0010,
        KEY_UNLK = 4'b0100,
        KEY_OPEN = 4'b1000
    } kwdt_key_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] write_data;
    } kwdt_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        reset_pulse;
        logic        irq_flag;
    } kwdt_out_t;

endpackage

`default_nettype wire

// ===== sv/kwdt_in_stage.sv =====
// ----------------------------------------------------------------------------
// kwdt_in_stage
// Input register: captures one transfer per cycle, unless the engine stalls,
// hands it on, with ready passed back combinationally so items flow each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kwdt_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire kwdt_pkg::kwdt_in_t s_data,
    output logic                  item_valid,
    input  wire logic             item_ready,
    output kwdt_pkg::kwdt_in_t    item_data
);
    import kwdt_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    kwdt_in_t data_reg;
    logic     take;

    // Accept when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || item_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (take) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/kwdt_engine.sv =====
// ----------------------------------------------------------------------------
// kwdt_engine
// Watchdog state, single-pass update for one item, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kwdt_engine #(
    parameter int unsigned BASE_TICKS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire kwdt_pkg::kwdt_in_t item_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output kwdt_pkg::kwdt_out_t     m_data
);
    import kwdt_pkg::*;

    // Count never reaches BASE_TICKS << 7; one spare bit holds count + 1
    localparam int unsigned CNT_W = $clog2(BASE_TICKS) + 8;
    localparam logic [CNT_W-1:0] BASE_CNT = CNT_W'(BASE_TICKS);

    logic                enable_reg, enable_next;
    logic                rsten_reg, rsten_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic                irq_reg, irq_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    kwdt_key_t           key_reg, key_next;
    logic                m_valid_reg, m_valid_next;
    kwdt_out_t           result_reg, result_next;

    logic                fire;
    logic [2:0]          exp_idx;
    logic [CNT_W-1:0]    threshold;
    logic [CNT_W-1:0]    count_inc;
    logic                pulse;
    kwdt_key_t           key_start;
    logic [15:0]         wdata;

    assign item_ready = !m_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;
    assign wdata      = item_data.write_data;

    // Pick the lowest set exponent bit, zero when none is set
    always_comb begin
        exp_idx = 3'd0;
        for (int i = EXP_BITS - 1; i >= 0; i--) begin
            if (exp_reg[i]) begin
                exp_idx = 3'(i);
            end
        end
    end

    assign threshold = BASE_CNT << exp_idx;
    assign count_inc = count_reg + CNT_W'(1);

    // Start a fresh key sequence on either first key word
    always_comb begin
        if (wdata == KEY_PING_A) begin
            key_start = KEY_PING;
        end else if (wdata == KEY_UNLK_A) begin
            key_start = KEY_UNLK;
        end else begin
            key_start = KEY_IDLE;
        end
    end

    // Update state for the item in hand
    always_comb begin
        enable_next = enable_reg;
        rsten_next  = rsten_reg;
        exp_next    = exp_reg;
        irq_next    = irq_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        pulse       = 1'b0;

        case (kwdt_op_t'(item_data.op))
            OP_TICK: begin
                if (enable_reg) begin
                    if (count_inc >= threshold) begin
                        count_next = '0;
                        if (rsten_reg) begin
                            pulse       = 1'b1;
                            enable_next = 1'b0;
                            rsten_next  = 1'b0;
                            exp_next    = '0;
                        end else begin
                            irq_next = 1'b1;
                        end
                    end else begin
                        count_next = count_inc;
                    end
                end
            end
            OP_WRITE: begin
                case (key_reg)
                    KEY_OPEN: begin
                        enable_next = wdata[BIT_ENABLE];
                        rsten_next  = wdata[BIT_RSTEN];
                        exp_next    = wdata[EXP_BITS-1:0];
                        if (wdata[BIT_IRQ]) begin
                            irq_next = 1'b0;
                        end
                        key_next = KEY_IDLE;
                    end
                    KEY_PING: begin
                        if (wdata == KEY_PING_B) begin
                            count_next = '0;
                            key_next   = KEY_IDLE;
                        end else begin
                            key_next = key_start;
                        end
                    end
                    KEY_UNLK: begin
                        if (wdata == KEY_UNLK_B) begin
                            key_next = KEY_OPEN;
                        end else begin
                            key_next = key_start;
                        end
                    end
                    default: begin
                        key_next = key_start;
                    end
                endcase
            end
            default: begin
                // Reads and the spare code change nothing
            end
        endcase
    end

    // Assemble the result from the updated state
    always_comb begin
        result_next.read_data             = '0;
        result_next.read_data[BIT_ENABLE] = enable_next;
        result_next.read_data[BIT_RSTEN]  = rsten_next;
        result_next.read_data[BIT_IRQ]    = irq_next;
        result_next.read_data[EXP_BITS-1:0] = exp_next;
        result_next.reset_pulse           = pulse;
        result_next.irq_flag              = irq_next;
    end

    always_comb begin
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Advance watchdog state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            rsten_reg   <= 1'b0;
            exp_reg     <= '0;
            irq_reg     <= 1'b0;
            count_reg   <= '0;
            key_reg     <= KEY_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                enable_reg <= enable_next;
                rsten_reg  <= rsten_next;
                exp_reg    <= exp_next;
                irq_reg    <= irq_next;
                count_reg  <= count_next;
                key_reg    <= key_next;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = result_reg;

endmodule

`default_nettype wire

// ===== sv/keyed_watchdog_timer_core.sv =====
// ----------------------------------------------------------------------------
// keyed_watchdog_timer_core
// Watchdog with one keyed 16-bit control word, driven by tick, write and read
// transfers and returning one status result per transfer.
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    kwdt_in_t  (op, write_data)
//   m_        out        m_valid / m_ready    kwdt_out_t (read_data,
//                                                         reset_pulse, irq_flag)
//
// One transfer is taken per cycle unless m_ready stalls; its result passes
// the input register and one update pass into the result register, where
// it is held until taken.
// Synchronous active-low reset clears the control word, irq flag, tick count
// and key sequence. A stalled m_ready holds the result and, once the input
// register is also full, drops s_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_watchdog_timer_core #(
    parameter int unsigned BASE_TICKS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire kwdt_pkg::kwdt_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output kwdt_pkg::kwdt_out_t      m_data
);
    import kwdt_pkg::*;

    logic     item_valid;
    logic     item_ready;
    kwdt_in_t item_data;

    // Register the incoming transfer
    kwdt_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data)
    );

    // Update watchdog state and register the result
    kwdt_engine #(
        .BASE_TICKS (BASE_TICKS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
